// ----- hdl/dpts_pkg.sv -----
// Shared types and constants for the DNA prefix trie scorer.
package dpts_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int COUNT_BITS_DEF = 16;
  localparam int DEPTH_BITS_DEF = 8;
  localparam int ALPHABET       = 4;
  localparam int CODE_BITS      = 2;
  localparam int SCORE_BITS     = 24;

  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_C = 8'h43;
  localparam logic [7:0] LETTER_G = 8'h47;
  localparam logic [7:0] LETTER_T = 8'h54;

  localparam logic [CODE_BITS-1:0] CODE_A = 2'd0;
  localparam logic [CODE_BITS-1:0] CODE_C = 2'd1;
  localparam logic [CODE_BITS-1:0] CODE_G = 2'd2;
  localparam logic [CODE_BITS-1:0] CODE_T = 2'd3;

  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] letter;
    logic       first_of_word;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] best_score;
    logic                  pool_full;
  } out_item_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ROW,
    S_ZERO,
    S_COUNT,
    S_SCORE
  } state_t;

endpackage

// ----- hdl/dna_prefix_trie_scorer_unit.sv -----
// Top level of the DNA prefix trie scorer: node pool memories, walk control and scoring.
// Steps: an insert letter reads its parent's child row, then either reads and rewrites the
// pass count of the child it walks to, or links a new node into the row and zeroes its row;
// a letter dropped on a full pool skips that step. Every item, clears too, ends in the score
// step, which waits on a stalled output and registers the result; only then is a new item taken.
// Reset: synchronous, active low; after release the init state zeroes the root's child row.
module dna_prefix_trie_scorer_unit #(
  parameter int NODE_COUNT = dpts_pkg::NODE_COUNT_DEF,
  parameter int COUNT_BITS = dpts_pkg::COUNT_BITS_DEF,
  parameter int DEPTH_BITS = dpts_pkg::DEPTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dpts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dpts_pkg::out_item_t out_data
);

  // Node index width. Node 0 stands for "no child" and node 1 is the root.
  localparam int NB    = $clog2(NODE_COUNT);
  localparam int ROW_W = dpts_pkg::ALPHABET * NB;
  localparam int PW    = DEPTH_BITS + COUNT_BITS;
  localparam int SW    = (PW > dpts_pkg::SCORE_BITS) ? PW : dpts_pkg::SCORE_BITS;

  localparam logic [NB-1:0]         ROOT      = NB'(1);
  localparam logic [NB-1:0]         LAST_FREE = NB'(NODE_COUNT - 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SW-1:0]         SCORE_MAX = SW'({dpts_pkg::SCORE_BITS{1'b1}});

  // Storage. Each child row holds the four child pointers of one node, so a new node's row
  // can be zeroed with a single write. A pass count is only ever read for a node allocated
  // since the last clear, and allocation writes it first, so the count memory needs no
  // clearing. The same holds for child rows: the root row is zeroed on reset and on clear,
  // and every other row is zeroed when its node is allocated.
  logic [ROW_W-1:0]      child_mem [NODE_COUNT];
  logic [COUNT_BITS-1:0] count_mem [NODE_COUNT];

  // Memory port controls.
  logic                  cm_we;
  logic [NB-1:0]         cm_waddr;
  logic [ROW_W-1:0]      cm_wdata;
  logic                  cm_re;
  logic [NB-1:0]         cm_raddr;
  logic                  pc_we;
  logic [NB-1:0]         pc_waddr;
  logic [COUNT_BITS-1:0] pc_wdata;
  logic                  pc_re;
  logic [NB-1:0]         pc_raddr;

  logic [ROW_W-1:0]      child_row_r;
  logic [COUNT_BITS-1:0] count_rd_r;

  // Walk and score state.
  dpts_pkg::state_t state_r, state_nxt;
  logic [NB-1:0]                   node_r;
  logic [DEPTH_BITS-1:0]           depth_r;
  logic [NB-1:0]                   next_free_r;
  logic [dpts_pkg::SCORE_BITS-1:0] best_r;
  logic                            full_r;
  logic [dpts_pkg::CODE_BITS-1:0]  code_r;
  logic [PW-1:0]                   prod_r;
  logic                            out_valid_r;
  dpts_pkg::out_item_t             out_data_r;

  // Decoded views used in several places.
  logic                            in_xfer;
  logic                            out_free;
  logic [NB-1:0]                   child;
  logic [NB-1:0]                   new_node;
  logic                            pool_empty;
  logic [DEPTH_BITS-1:0]           depth_inc;
  logic [COUNT_BITS-1:0]           count_inc;
  logic [ROW_W-1:0]                row_mod;
  logic [SW-1:0]                   prod_w;
  logic [dpts_pkg::SCORE_BITS-1:0] score;
  logic [dpts_pkg::SCORE_BITS-1:0] best_nxt;

  // Any letter other than A, C, G or T counts as C.
  function automatic logic [dpts_pkg::CODE_BITS-1:0] base_code(input logic [7:0] ch);
    logic [dpts_pkg::CODE_BITS-1:0] code;
    unique case (ch)
      dpts_pkg::LETTER_A: code = dpts_pkg::CODE_A;
      dpts_pkg::LETTER_C: code = dpts_pkg::CODE_C;
      dpts_pkg::LETTER_G: code = dpts_pkg::CODE_G;
      dpts_pkg::LETTER_T: code = dpts_pkg::CODE_T;
      default:            code = dpts_pkg::CODE_C;
    endcase
    return code;
  endfunction

  assign in_stall  = (state_r != dpts_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign child      = child_row_r[code_r * NB +: NB];
  assign pool_empty = (next_free_r == LAST_FREE);
  assign new_node   = next_free_r + NB'(1);
  assign depth_inc  = (depth_r == DEPTH_MAX) ? depth_r : depth_r + DEPTH_BITS'(1);
  assign count_inc  = (count_rd_r == COUNT_MAX) ? count_rd_r : count_rd_r + COUNT_BITS'(1);

  always_comb begin
    row_mod = child_row_r;
    row_mod[code_r * NB +: NB] = new_node;
  end

  // Products beyond 24 bits saturate; the running best only grows until a clear or reset zeroes it.
  assign prod_w   = SW'(prod_r);
  assign score    = (prod_w > SCORE_MAX) ? dpts_pkg::SCORE_BITS'(SCORE_MAX)
                                         : prod_w[dpts_pkg::SCORE_BITS-1:0];
  assign best_nxt = (score > best_r) ? score : best_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpts_pkg::S_INIT: state_nxt = dpts_pkg::S_IDLE;
      dpts_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_data.mode == dpts_pkg::MODE_INSERT) ? dpts_pkg::S_ROW
                                                               : dpts_pkg::S_SCORE;
        end
      end
      dpts_pkg::S_ROW: begin
        if (child != '0) begin
          state_nxt = dpts_pkg::S_COUNT;
        end else if (pool_empty) begin
          state_nxt = dpts_pkg::S_SCORE;
        end else begin
          state_nxt = dpts_pkg::S_ZERO;
        end
      end
      dpts_pkg::S_ZERO:  state_nxt = dpts_pkg::S_SCORE;
      dpts_pkg::S_COUNT: state_nxt = dpts_pkg::S_SCORE;
      dpts_pkg::S_SCORE: begin
        if (out_free) begin
          state_nxt = dpts_pkg::S_IDLE;
        end
      end
      default: state_nxt = dpts_pkg::S_INIT;
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = ROOT;
    cm_wdata = '0;
    cm_re    = 1'b0;
    cm_raddr = ROOT;
    pc_we    = 1'b0;
    pc_waddr = node_r;
    pc_wdata = count_inc;
    pc_re    = 1'b0;
    pc_raddr = child;
    unique case (state_r)
      dpts_pkg::S_INIT: cm_we = 1'b1;
      dpts_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_data.mode == dpts_pkg::MODE_INSERT) begin
            cm_re    = 1'b1;
            cm_raddr = in_data.first_of_word ? ROOT : node_r;
          end else begin
            cm_we = 1'b1;
          end
        end
      end
      dpts_pkg::S_ROW: begin
        if (child != '0) begin
          pc_re = 1'b1;
        end else if (!pool_empty) begin
          // Link the new node into its parent's row and give it its first pass.
          cm_we    = 1'b1;
          cm_waddr = node_r;
          cm_wdata = row_mod;
          pc_we    = 1'b1;
          pc_waddr = new_node;
          pc_wdata = COUNT_BITS'(1);
        end
      end
      dpts_pkg::S_ZERO: begin
        cm_we    = 1'b1;
        cm_waddr = node_r;
      end
      dpts_pkg::S_COUNT: pc_we = 1'b1;
      dpts_pkg::S_SCORE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      child_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      child_row_r <= child_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      count_mem[pc_waddr] <= pc_wdata;
    end
    if (pc_re) begin
      count_rd_r <= count_mem[pc_raddr];
    end
  end

  // Walk state, score and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpts_pkg::S_INIT;
      node_r      <= ROOT;
      depth_r     <= '0;
      next_free_r <= ROOT;
      best_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // A new result may replace one that leaves in the same cycle.
      if (state_r == dpts_pkg::S_SCORE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        dpts_pkg::S_INIT: ;
        dpts_pkg::S_IDLE: begin
          if (in_xfer) begin
            code_r <= base_code(in_data.letter);
            prod_r <= '0;
            if (in_data.mode == dpts_pkg::MODE_CLEAR) begin
              node_r      <= ROOT;
              depth_r     <= '0;
              next_free_r <= ROOT;
              best_r      <= '0;
              full_r      <= 1'b0;
            end else if (in_data.first_of_word) begin
              // The walk restarts at the root even if this letter is later dropped.
              node_r  <= ROOT;
              depth_r <= '0;
            end
          end
        end
        dpts_pkg::S_ROW: begin
          if (child != '0) begin
            node_r  <= child;
            depth_r <= depth_inc;
          end else if (pool_empty) begin
            full_r <= 1'b1;
          end else begin
            next_free_r <= new_node;
            node_r      <= new_node;
            depth_r     <= depth_inc;
            prod_r      <= PW'(depth_inc);
          end
        end
        dpts_pkg::S_ZERO: ;
        dpts_pkg::S_COUNT: prod_r <= PW'(depth_r) * PW'(count_inc);
        dpts_pkg::S_SCORE: begin
          // The max is idempotent, so waiting here on a stalled output is harmless.
          best_r <= best_nxt;
          if (out_free) begin
            out_data_r.best_score <= best_nxt;
            out_data_r.pool_full  <= full_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/dpts_checker.sv -----
// Port-level checker for the DNA prefix trie scorer, bound to the top level.
module dpts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dpts_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dpts_pkg::out_item_t out_data
);

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // A stalled input item stays offered and unchanged until the transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed or vanished");

  // The block works on one item at a time, so it is busy right after an input transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // A new result only appears right after the block was busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Reset empties the output and holds off input while the root row is cleared.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("reset did not clear the handshake state");

endmodule

bind dna_prefix_trie_scorer_unit dpts_checker u_dpts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
